// File: rtl/rba_pkg.sv
// ----------------------------------------------------------------------------
// rba_pkg
// Shared widths, angle constants, arctangent table and pipeline control
// types for the relative bearing pipeline.
// ----------------------------------------------------------------------------
package rba_pkg;

  // datapath widths
  localparam int W_IN  = 32;   // Q16.16 position inputs
  localparam int W_D   = 33;   // exact difference of two inputs
  localparam int W_XY  = 36;   // cordic vector with gain headroom
  localparam int W_Z   = 20;   // one cordic angle, Q.16 radians
  localparam int W_A   = 21;   // sum of two angles, Q.16 radians
  localparam int W_Q   = 18;   // angle after rounding to Q3.13
  localparam int W_OUT = 16;   // output angle, Q3.13

  localparam int TABLE_LEN = 24;

  // angle constants
  localparam logic signed [W_Z-1:0]   HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [W_A-1:0]   PI_Q16      = 21'sd205887;
  localparam logic signed [W_A-1:0]   TWO_PI_Q16  = 21'sd411775;
  localparam logic signed [W_Q-1:0]   PI_Q13      = 18'sd25736;
  localparam logic signed [W_OUT-1:0] PI_OUT      = 16'sd25736;

  // side information that travels with an item
  typedef struct packed {
    logic op;         // 1: trajectory, subtract reference angle
    logic no_motion;  // trajectory without dynamics, result is pi
  } tag_t;

  // per-stage control of a cordic lane
  typedef struct packed {
    logic valid;
    logic zero;       // input vector was zero, angle reads as 0
    tag_t tag;
  } ctl_t;

  // arctangent of 2^-idx in Q.16 radians
  function automatic logic signed [W_Z-1:0] atan_q16(input int idx);
    logic signed [W_Z-1:0] v;
    unique case (idx)
      0:  v = 20'sd51472;
      1:  v = 20'sd30386;
      2:  v = 20'sd16055;
      3:  v = 20'sd8150;
      4:  v = 20'sd4091;
      5:  v = 20'sd2047;
      6:  v = 20'sd1024;
      7:  v = 20'sd512;
      8:  v = 20'sd256;
      9:  v = 20'sd128;
      10: v = 20'sd64;
      11: v = 20'sd32;
      12: v = 20'sd16;
      13: v = 20'sd8;
      14: v = 20'sd4;
      15: v = 20'sd2;
      16: v = 20'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/relative_bearing_angle_top.sv
// ----------------------------------------------------------------------------
// relative_bearing_angle_top
// Relative bearing from observer, target and reference direction, using two
// lockstep cordic pipelines and a combine/wrap/round tail.
// ----------------------------------------------------------------------------
// Path to done: input register, prerotation, cordic stages, then the combine registers.
// Throughput: one item per cycle; every stage is one shift-add or add-compare.
// busy is high only during reset; the result pipeline never stalls.
// Reset (synchronous, rst high) clears all valid bits; no item is in flight.
// ----------------------------------------------------------------------------
module relative_bearing_angle_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op,
  input  logic signed [rba_pkg::W_IN-1:0]   observer_x,
  input  logic signed [rba_pkg::W_IN-1:0]   observer_y,
  input  logic signed [rba_pkg::W_IN-1:0]   target_x,
  input  logic signed [rba_pkg::W_IN-1:0]   target_y,
  input  logic signed [rba_pkg::W_IN-1:0]   ref_y,
  input  logic signed [rba_pkg::W_IN-1:0]   ref_x,
  input  logic                              has_motion,
  output logic                              done,
  output logic signed [rba_pkg::W_OUT-1:0]  angle
);
  import rba_pkg::*;

  localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  logic                  s0_valid;
  tag_t                  s0_tag;
  logic signed [W_D-1:0] dx, dy, rx, ry;
  logic                  ca_valid;
  tag_t                  ca_tag;
  logic signed [W_Z-1:0] za, zb;

  assign busy = rst;

  // input transfer register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  // position differences and reference capture
  always_ff @(posedge clk) begin
    dx               <= W_D'(target_x) - W_D'(observer_x);
    dy               <= W_D'(target_y) - W_D'(observer_y);
    rx               <= W_D'(ref_x);
    ry               <= W_D'(ref_y);
    s0_tag.op        <= op;
    s0_tag.no_motion <= op && !has_motion;
  end

  // line of sight angle
  rba_cordic #(
    .NSTG(NSTG)
  ) u_cordic_los (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s0_valid),
    .in_tag   (s0_tag),
    .in_x     (dx),
    .in_y     (dy),
    .out_valid(ca_valid),
    .out_tag  (ca_tag),
    .out_z    (za)
  );

  // reference angle
  rba_cordic #(
    .NSTG(NSTG)
  ) u_cordic_ref (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s0_valid),
    .in_tag   (s0_tag),
    .in_x     (rx),
    .in_y     (ry),
    .out_valid(),
    .out_tag  (),
    .out_z    (zb)
  );

  // combine, wrap and round
  rba_combine u_combine (
    .clk     (clk),
    .rst     (rst),
    .in_valid(ca_valid),
    .in_tag  (ca_tag),
    .in_za   (za),
    .in_zb   (zb),
    .done    (done),
    .angle   (angle)
  );

endmodule

// File: rtl/rba_cordic_stage.sv
// ----------------------------------------------------------------------------
// rba_cordic_stage
// One registered vectoring iteration: rotates toward the x axis by
// atan(2^-IDX) and accumulates the rotation in the angle register.
// ----------------------------------------------------------------------------
module rba_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rba_pkg::ctl_t                     in_ctl,
  input  logic signed [rba_pkg::W_XY-1:0]   in_x,
  input  logic signed [rba_pkg::W_XY-1:0]   in_y,
  input  logic signed [rba_pkg::W_Z-1:0]    in_z,
  output rba_pkg::ctl_t                     out_ctl,
  output logic signed [rba_pkg::W_XY-1:0]   out_x,
  output logic signed [rba_pkg::W_XY-1:0]   out_y,
  output logic signed [rba_pkg::W_Z-1:0]    out_z
);
  import rba_pkg::*;

  localparam logic signed [W_Z-1:0] ANG = atan_q16(IDX);

  logic signed [W_XY-1:0] xs;
  logic signed [W_XY-1:0] ys;
  logic signed [W_XY-1:0] x_next;
  logic signed [W_XY-1:0] y_next;
  logic signed [W_Z-1:0]  z_next;

  // shift-add rotation, direction from the sign of y
  always_comb begin
    xs = in_x >>> IDX;
    ys = in_y >>> IDX;
    if (!in_y[W_XY-1]) begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + ANG;
    end else begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - ANG;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_x <= x_next;
    out_y <= y_next;
    out_z <= z_next;
  end

endmodule

// File: rtl/rba_cordic.sv
// ----------------------------------------------------------------------------
// rba_cordic
// Pipelined vectoring cordic for atan2(y, x): a prerotation stage into the
// right half plane, then NSTG shift-add stages. A zero vector yields 0.
// ----------------------------------------------------------------------------
module rba_cordic #(
  parameter int NSTG = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  rba_pkg::tag_t                    in_tag,
  input  logic signed [rba_pkg::W_D-1:0]   in_x,
  input  logic signed [rba_pkg::W_D-1:0]   in_y,
  output logic                             out_valid,
  output rba_pkg::tag_t                    out_tag,
  output logic signed [rba_pkg::W_Z-1:0]   out_z
);
  import rba_pkg::*;

  ctl_t                   ctl [0:NSTG];
  logic signed [W_XY-1:0] xv  [0:NSTG];
  logic signed [W_XY-1:0] yv  [0:NSTG];
  logic signed [W_Z-1:0]  zv  [0:NSTG];

  logic signed [W_XY-1:0] xe;
  logic signed [W_XY-1:0] ye;
  logic signed [W_XY-1:0] x_next;
  logic signed [W_XY-1:0] y_next;
  logic signed [W_Z-1:0]  z_next;
  ctl_t                   ctl_next;

  // prerotation by -/+ pi/2 when the vector lies in the left half plane
  always_comb begin
    xe = W_XY'(in_x);
    ye = W_XY'(in_y);
    ctl_next.valid = in_valid;
    ctl_next.zero  = (in_x == '0) && (in_y == '0);
    ctl_next.tag   = in_tag;
    if (!in_x[W_D-1]) begin
      x_next = xe;
      y_next = ye;
      z_next = '0;
    end else if (!in_y[W_D-1]) begin
      x_next = ye;
      y_next = -xe;
      z_next = HALF_PI_Q16;
    end else begin
      x_next = -ye;
      y_next = xe;
      z_next = -HALF_PI_Q16;
    end
  end

  // prerotation control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else begin
      ctl[0] <= ctl_next;
    end
  end

  // prerotation payload
  always_ff @(posedge clk) begin
    xv[0] <= x_next;
    yv[0] <= y_next;
    zv[0] <= z_next;
  end

  // iteration chain
  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    rba_cordic_stage #(
      .IDX(i)
    ) u_stage (
      .clk    (clk),
      .rst    (rst),
      .in_ctl (ctl[i]),
      .in_x   (xv[i]),
      .in_y   (yv[i]),
      .in_z   (zv[i]),
      .out_ctl(ctl[i+1]),
      .out_x  (xv[i+1]),
      .out_y  (yv[i+1]),
      .out_z  (zv[i+1])
    );
  end

  // zero vector reads as angle 0
  assign out_valid = ctl[NSTG].valid;
  assign out_tag   = ctl[NSTG].tag;
  assign out_z     = ctl[NSTG].zero ? '0 : zv[NSTG];

endmodule

// File: rtl/rba_combine.sv
// ----------------------------------------------------------------------------
// rba_combine
// Adds or subtracts the two cordic angles, wraps once into -pi..pi,
// rounds to Q3.13 with saturation and applies the no-motion override.
// ----------------------------------------------------------------------------
module rba_combine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  rba_pkg::tag_t                     in_tag,
  input  logic signed [rba_pkg::W_Z-1:0]    in_za,
  input  logic signed [rba_pkg::W_Z-1:0]    in_zb,
  output logic                              done,
  output logic signed [rba_pkg::W_OUT-1:0]  angle
);
  import rba_pkg::*;

  logic                   v1, v2, v3;
  logic                   nm1, nm2, nm3;
  logic signed [W_A-1:0]  a1, a2, a3;
  logic signed [W_A-1:0]  sum_next;
  logic signed [W_A-1:0]  lo_next;
  logic signed [W_A-1:0]  hi_next;
  logic signed [W_A-1:0]  rnd;
  logic signed [W_Q-1:0]  q;
  logic signed [W_OUT-1:0] angle_next;

  // sum or difference of the two angles
  always_comb begin
    if (in_tag.op) begin
      sum_next = W_A'(in_za) - W_A'(in_zb);
    end else begin
      sum_next = W_A'(in_za) + W_A'(in_zb);
    end
  end

  // lower wrap, then upper wrap
  assign lo_next = (a1 <= -PI_Q16) ? a1 + TWO_PI_Q16 : a1;
  assign hi_next = (a2 >= PI_Q16) ? a2 - TWO_PI_Q16 : a2;

  // round to nearest, saturate, override for no motion
  always_comb begin
    rnd = a3 + W_A'(4);
    q   = W_Q'(rnd >>> 3);
    if (nm3) begin
      angle_next = PI_OUT;
    end else if (q > PI_Q13) begin
      angle_next = PI_OUT;
    end else if (q < -PI_Q13) begin
      angle_next = -PI_OUT;
    end else begin
      angle_next = W_OUT'(q);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // payload chain
  always_ff @(posedge clk) begin
    a1    <= sum_next;
    nm1   <= in_tag.no_motion;
    a2    <= lo_next;
    nm2   <= nm1;
    a3    <= hi_next;
    nm3   <= nm2;
    angle <= angle_next;
  end

endmodule

// File: bench/relative_bearing_angle_top_tb.sv
// ----------------------------------------------------------------------------
// relative_bearing_angle_top_tb
// Self-checking bench for the relative bearing pipeline. A directed set
// covers zero vectors, full-scale differences, axis cases, the pi override
// and wrap boundaries; then random queries run with random start gaps. Each
// accepted query is run through a bit-true cordic model in the scoreboard,
// and every done strobe is checked in order against the predicted angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module relative_bearing_angle_top_tb;

  localparam int STAGES         = 16;
  localparam int LATENCY        = ((STAGES < 24) ? STAGES : 24) + 6;
  localparam int NUM_RANDOM     = 1200;
  localparam int WATCHDOG_LIMIT = 4000;

  // operation codes
  localparam logic OP_SIGHT = 1'b0;
  localparam logic OP_TRAJ  = 1'b1;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic               op;
    logic signed [31:0] observer_x;
    logic signed [31:0] observer_y;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_x;
    logic               has_motion;
  } bearing_req_t;

  // expected angles and the bit-true bearing predictor
  class bearing_scoreboard;
    localparam longint HALF_PI = 102944;
    localparam longint PI      = 205887;
    localparam longint TWO_PI  = 411775;
    localparam longint PI_OUT  = 25736;

    longint atan_table[24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2,
                               1, 0, 0, 0, 0, 0, 0, 0};
    logic signed [15:0] expected_angles[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // vectoring cordic, angle in Q.16 radians
    function longint arctan_q16(longint y, longint x);
      longint z;
      longint t;
      longint xs;
      longint ys;
      int i;
      z = 0;
      if (x == 0 && y == 0) return 0;
      // fold left half plane onto the right one
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = HALF_PI;
        end else begin
          t = x; x = -y; y = t; z = -HALF_PI;
        end
      end
      for (i = 0; i < STAGES && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + atan_table[i];
        end else begin
          x = x - ys; y = y + xs; z = z - atan_table[i];
        end
      end
      return z;
    endfunction

    function logic signed [15:0] predict_angle(bearing_req_t r);
      longint a;
      longint q;
      longint ref_angle;
      if (r.op == OP_TRAJ && !r.has_motion) return PI_OUT[15:0];
      a = arctan_q16(longint'(r.target_y) - longint'(r.observer_y),
                     longint'(r.target_x) - longint'(r.observer_x));
      ref_angle = arctan_q16(longint'(r.ref_y), longint'(r.ref_x));
      if (r.op == OP_SIGHT) a = a + ref_angle;
      else a = a - ref_angle;
      // single wrap into -pi..pi
      if (a <= -PI) a = a + TWO_PI;
      if (a >= PI) a = a - TWO_PI;
      // round to Q3.13, ties up, then clamp
      q = (a + 4) >>> 3;
      if (q > PI_OUT) q = PI_OUT;
      if (q < -PI_OUT) q = -PI_OUT;
      return q[15:0];
    endfunction

    function void note_input(bearing_req_t r);
      expected_angles.push_back(predict_angle(r));
    endfunction

    function void check_result(logic signed [15:0] got);
      logic signed [15:0] want;
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result, expected none, got angle %0d", $time, got);
        errors++;
        return;
      end
      want = expected_angles.pop_front();
      if (got !== want) begin
        $display("%0t: angle mismatch, expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  logic signed [15:0] angle;
  bearing_req_t req = '0;
  bearing_scoreboard sb = new();
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  relative_bearing_angle_top #(
    .CORDIC_STAGES(STAGES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(req.op),
    .observer_x(req.observer_x),
    .observer_y(req.observer_y),
    .target_x(req.target_x),
    .target_y(req.target_y),
    .ref_y(req.ref_y),
    .ref_x(req.ref_x),
    .has_motion(req.has_motion),
    .done(done),
    .angle(angle)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // monitor: check results, note accepted queries, watchdog
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) begin
        sb.check_result(angle);
        moved = 1'b1;
      end
      if (start && !busy) begin
        sb.note_input(req);
        moved = 1'b1;
      end
      if (moved) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, sb.expected_angles.size());
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function bearing_req_t make_req(logic op, logic signed [31:0] ox, logic signed [31:0] oy,
                                  logic signed [31:0] tx, logic signed [31:0] ty,
                                  logic signed [31:0] ry, logic signed [31:0] rx,
                                  logic motion);
    bearing_req_t r;
    r.op = op;
    r.observer_x = ox;
    r.observer_y = oy;
    r.target_x = tx;
    r.target_y = ty;
    r.ref_y = ry;
    r.ref_x = rx;
    r.has_motion = motion;
    return r;
  endfunction

  function logic signed [31:0] near_zero();
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  function bearing_req_t random_req();
    bearing_req_t r;
    r = make_req(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, ($urandom_range(0, 3) != 0));
    case ($urandom_range(0, 9))
      4, 5: begin
        // short vectors near the origin
        r.target_x = r.observer_x + near_zero();
        r.target_y = r.observer_y + near_zero();
        r.ref_y = near_zero();
        r.ref_x = near_zero();
      end
      6: begin
        // target on top of the observer
        r.target_x = r.observer_x;
        r.target_y = r.observer_y;
      end
      7: begin
        r.ref_y = '0;
        r.ref_x = '0;
      end
      8: begin
        // axis aligned difference
        if ($urandom_range(0, 1)) r.target_y = r.observer_y;
        else r.target_x = r.observer_x;
      end
      9: begin
        // reference close to the negative x axis, drives the wrap
        r.ref_x = -int'($urandom_range(1 << 20, 1 << 30));
        r.ref_y = near_zero();
      end
      default: ;
    endcase
    return r;
  endfunction

  // one start transfer; inputs change at the falling edge
  task send_req(input bearing_req_t r);
    @(negedge clk);
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // random start gaps with junk on the payload
  task start_gap();
    int n;
    n = 0;
    if (gaps_on) begin
      if ($urandom_range(0, 39) == 0) n = $urandom_range(1, LATENCY + 8);
      else while ($urandom_range(0, 99) < 36) n++;
    end
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      req <= random_req();
    end
  endtask

  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_angles.size() != 0) @(posedge clk);
  endtask

  initial begin
    bearing_req_t directed[$];
    int k;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero vectors, pi override, motion ignored when sighting
    directed.push_back(make_req(OP_SIGHT, 0, 0, 0, 0, 0, 0, 1'b0));
    directed.push_back(make_req(OP_TRAJ, 0, 0, 0, 0, 0, 0, 1'b1));
    directed.push_back(make_req(OP_TRAJ, 5, -7, Q_MAX, Q_MIN, 3, -3, 1'b0));
    directed.push_back(make_req(OP_SIGHT, 5, -7, 900, 1200, 300, -400, 1'b0));
    directed.push_back(make_req(OP_SIGHT, 5, -7, 900, 1200, 300, -400, 1'b1));
    // full-scale differences
    directed.push_back(make_req(OP_SIGHT, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    directed.push_back(make_req(OP_TRAJ, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
    directed.push_back(make_req(OP_SIGHT, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0));
    directed.push_back(make_req(OP_TRAJ, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1));
    // negative x axis, both operations
    directed.push_back(make_req(OP_SIGHT, 100, 0, -100, 0, 0, 1, 1'b1));
    directed.push_back(make_req(OP_SIGHT, 100, 0, -100, 0, 0, -1, 1'b1));
    directed.push_back(make_req(OP_TRAJ, 100, 0, -100, 0, 0, -1, 1'b1));
    // wrap boundaries around -pi and +pi
    directed.push_back(make_req(OP_TRAJ, 0, 0, -1000, -1000, 1000, 1000, 1'b1));
    directed.push_back(make_req(OP_TRAJ, 0, 0, -65536, -1, 1, -65536, 1'b1));
    directed.push_back(make_req(OP_SIGHT, 0, 0, -65536, 1, 1, -65536, 1'b1));
    directed.push_back(make_req(OP_SIGHT, 0, 0, -1000, 1000, 1000, -1000, 1'b1));
    // y axis and zero reference
    directed.push_back(make_req(OP_SIGHT, 0, 0, 0, 777, 0, 0, 1'b0));
    directed.push_back(make_req(OP_TRAJ, 0, 0, 0, -777, 0, 0, 1'b1));
    directed.push_back(make_req(OP_TRAJ, -3, -3, -3, -3, Q_MIN, 0, 1'b1));
    directed.push_back(make_req(OP_SIGHT, 42, 42, 42, 42, 0, Q_MIN, 1'b1));
    directed.push_back(make_req(OP_TRAJ, 1, 1, 2, 2, -1, -1, 1'b1));

    foreach (directed[i]) begin
      send_req(directed[i]);
      start_gap();
    end
    drain();

    // random queries: a gap-free stretch and one full drain in the middle
    for (k = 0; k < NUM_RANDOM; k++) begin
      gaps_on = !(k >= 300 && k < 500);
      if (k == 700) drain();
      send_req(random_req());
      start_gap();
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_angles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
